### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_LIN,
      KIND_BZERO,
      KIND_GEN
   } kind_type;

endpackage

`default_nettype wire

### rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, with a round-up
// flag (twice the remainder reaches the divisor) and a sideband that travels
// with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 34,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic             out_rnd,
   output logic [SB_W-1:0]  out_sb
);

   logic             vld_ff [1:NUM_W];
   logic [NUM_W-1:0] num_ff [1:NUM_W];
   logic [DEN_W-1:0] rem_ff [1:NUM_W];
   logic [DEN_W-1:0] den_ff [1:NUM_W];
   logic [SB_W-1:0]  sb_ff  [1:NUM_W];

   genvar k;
   for (k = 0; k < NUM_W; k++) begin : g_stage
      logic             src_vld;
      logic [NUM_W-1:0] src_num;
      logic [DEN_W-1:0] src_rem;
      logic [DEN_W-1:0] src_den;
      logic [SB_W-1:0]  src_sb;
      logic [DEN_W:0]   part;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [NUM_W-1:0] num_in;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_num = in_num;
         assign src_rem = '0;
         assign src_den = in_den;
         assign src_sb  = in_sb;
      end else begin : g_next
         assign src_vld = vld_ff[k];
         assign src_num = num_ff[k];
         assign src_rem = rem_ff[k];
         assign src_den = den_ff[k];
         assign src_sb  = sb_ff[k];
      end

      assign part   = {src_rem, src_num[NUM_W-1]};
      assign ge     = part >= {1'b0, src_den};
      assign diff   = part - {1'b0, src_den};
      assign rem_in = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      assign num_in = {src_num[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         num_ff[k+1] <= num_in;
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= src_den;
         sb_ff[k+1]  <= src_sb;
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= src_vld;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quo   = num_ff[NUM_W];
   assign out_rnd   = {rem_ff[NUM_W], 1'b0} >= {1'b0, den_ff[NUM_W]};
   assign out_sb    = sb_ff[NUM_W];

endmodule

`default_nettype wire

### rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root (floor), one root bit per stage, with a
// sideband that travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt #(
   parameter int RAD_W = 66,
   parameter int SB_W  = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_rad,
   input  logic [SB_W-1:0]    in_sb,
   output logic               out_valid,
   output logic [RAD_W/2-1:0] out_root,
   output logic [SB_W-1:0]    out_sb
);

   localparam int RT_W  = RAD_W / 2;
   localparam int REM_W = RT_W + 1;

   logic             vld_ff  [1:RT_W];
   logic [RAD_W-1:0] rad_ff  [1:RT_W];
   logic [RT_W-1:0]  root_ff [1:RT_W];
   logic [REM_W-1:0] rem_ff  [1:RT_W];
   logic [SB_W-1:0]  sb_ff   [1:RT_W];

   genvar k;
   for (k = 0; k < RT_W; k++) begin : g_stage
      logic             src_vld;
      logic [RAD_W-1:0] src_rad;
      logic [RT_W-1:0]  src_root;
      logic [REM_W-1:0] src_rem;
      logic [SB_W-1:0]  src_sb;
      logic [REM_W+1:0] part;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             ge;
      logic [REM_W-1:0] rem_in;
      logic [RT_W-1:0]  root_in;
      logic [RAD_W-1:0] rad_in;

      if (k == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rad  = in_rad;
         assign src_root = '0;
         assign src_rem  = '0;
         assign src_sb   = in_sb;
      end else begin : g_next
         assign src_vld  = vld_ff[k];
         assign src_rad  = rad_ff[k];
         assign src_root = root_ff[k];
         assign src_rem  = rem_ff[k];
         assign src_sb   = sb_ff[k];
      end

      assign part    = {src_rem, src_rad[RAD_W-1:RAD_W-2]};
      assign trial   = {1'b0, src_root, 2'b01};
      assign ge      = part >= trial;
      assign diff    = part - trial;
      assign rem_in  = ge ? diff[REM_W-1:0] : part[REM_W-1:0];
      assign root_in = {src_root[RT_W-2:0], ge};
      assign rad_in  = {src_rad[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         rad_ff[k+1]  <= rad_in;
         root_ff[k+1] <= root_in;
         rem_ff[k+1]  <= rem_in;
         sb_ff[k+1]   <= src_sb;
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= src_vld;
         end
      end
   end

   assign out_valid = vld_ff[RT_W];
   assign out_root  = root_ff[RT_W];
   assign out_sb    = sb_ff[RT_W];

endmodule

`default_nettype wire

### rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, stable form.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req_coef_a/b/c) is taken at a rising edge with req_start high
//   and busy low. busy is high during reset and in the first cycle after it;
//   otherwise an item may be offered in every cycle.
//   Each item gives one result, shown for one cycle with rsp_strobe high:
//   rsp_root_count, rsp_first_root, rsp_second_root, rsp_saturated.
//   The receiver cannot stall; results leave in input order.
//   The path runs through the input, sign, product and discriminant registers,
//   the bit-per-stage pipelines of the c/a divider and the square root unit,
//   the operand register, the two root dividers running side by side, and the
//   rounding, clip and output registers.
//   Throughput: one item per cycle.
//   Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_top #(
   parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   output logic                        busy,
   input  logic signed [WORD_BITS-1:0] req_coef_a,
   input  logic signed [WORD_BITS-1:0] req_coef_b,
   input  logic signed [WORD_BITS-1:0] req_coef_c,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_root_count,
   output logic signed [WORD_BITS-1:0] rsp_first_root,
   output logic signed [WORD_BITS-1:0] rsp_second_root,
   output logic                        rsp_saturated
);

   import qrs_pkg::*;

   localparam int W      = WORD_BITS;
   localparam int F      = FRAC_BITS;
   localparam int KIND_W = $bits(kind_type);
   localparam int DISC_W = 2 * W + 2;
   localparam int RNUM_W = W + 2 * F;
   localparam int SQ_RAW = (DISC_W > RNUM_W) ? DISC_W : RNUM_W;
   localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
   localparam int RT_W   = SQ_W / 2;
   localparam int T_W    = W + 2;
   localparam int QN_W   = W + F + 2;
   localparam int QR_W   = QN_W + 1;
   localparam int EM_W   = (QR_W > RT_W) ? QR_W : RT_W;
   localparam int SB1_W  = KIND_W + DISC_W + 3 * W + 3;
   localparam int SB2_W  = KIND_W + 3 * W + 3;
   localparam int SBA_W  = KIND_W + RT_W + 1;

   function automatic logic [W:0] clip(input logic [EM_W-1:0] mag, input logic neg);
      logic [EM_W-1:0] half;
      logic [EM_W-1:0] lim;
      logic [EM_W-1:0] val;
      logic            sat;
      logic [W-1:0]    res;
      half = EM_W'(1) << (W - 1);
      lim  = neg ? half : half - EM_W'(1);
      sat  = mag > lim;
      val  = sat ? lim : mag;
      res  = val[W-1:0];
      if (neg) begin
         res = ~res + W'(1);
      end
      return {sat, res};
   endfunction

   // busy only right after reset
   logic busy_ff;
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // input register
   logic         v0_ff;
   logic [W-1:0] a0_ff, b0_ff, c0_ff;
   always_ff @(posedge clock) begin
      a0_ff <= req_coef_a;
      b0_ff <= req_coef_b;
      c0_ff <= req_coef_c;
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= req_start && !busy_ff;
      end
   end

   // sign and magnitude
   logic         v1_ff;
   logic [W-1:0] ma1_ff, mb1_ff, mc1_ff;
   logic         na1_ff, nb1_ff, nc1_ff;
   always_ff @(posedge clock) begin
      na1_ff <= a0_ff[W-1];
      nb1_ff <= b0_ff[W-1];
      nc1_ff <= c0_ff[W-1];
      ma1_ff <= a0_ff[W-1] ? (~a0_ff + W'(1)) : a0_ff;
      mb1_ff <= b0_ff[W-1] ? (~b0_ff + W'(1)) : b0_ff;
      mc1_ff <= c0_ff[W-1] ? (~c0_ff + W'(1)) : c0_ff;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
   end

   // products b*b and a*c
   logic           v2_ff;
   logic [2*W-1:0] b2_in, amc_in;
   logic [2*W-1:0] b2_ff, amc_ff;
   logic [W-1:0]   ma2_ff, mb2_ff, mc2_ff;
   logic           na2_ff, nb2_ff, nc2_ff;
   assign b2_in  = (2*W)'(mb1_ff) * (2*W)'(mb1_ff);
   assign amc_in = (2*W)'(ma1_ff) * (2*W)'(mc1_ff);
   always_ff @(posedge clock) begin
      b2_ff  <= b2_in;
      amc_ff <= amc_in;
      ma2_ff <= ma1_ff;
      mb2_ff <= mb1_ff;
      mc2_ff <= mc1_ff;
      na2_ff <= na1_ff;
      nb2_ff <= nb1_ff;
      nc2_ff <= nc1_ff;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // discriminant and case
   logic              v3_ff;
   logic [DISC_W-1:0] b2x, p4, disc_in, disc3_ff;
   logic              ac_neg, disc_ok;
   kind_type          kind3_in, kind3_ff;
   logic [W-1:0]      ma3_ff, mb3_ff, mc3_ff;
   logic              na3_ff, nb3_ff, nc3_ff;
   assign b2x     = {2'b00, b2_ff};
   assign p4      = {amc_ff, 2'b00};
   assign ac_neg  = (mc2_ff != '0) && (na2_ff != nc2_ff);
   assign disc_ok = ac_neg || (b2x >= p4);
   assign disc_in = ac_neg ? (b2x + p4) : (b2x - p4);
   always_comb begin
      priority if (ma2_ff == '0) begin
         kind3_in = (mb2_ff == '0) ? KIND_NONE : KIND_LIN;
      end else if (!disc_ok) begin
         kind3_in = KIND_NONE;
      end else if (mb2_ff == '0) begin
         kind3_in = KIND_BZERO;
      end else begin
         kind3_in = KIND_GEN;
      end
   end
   always_ff @(posedge clock) begin
      disc3_ff <= disc_in;
      kind3_ff <= kind3_in;
      ma3_ff   <= ma2_ff;
      mb3_ff   <= mb2_ff;
      mc3_ff   <= mc2_ff;
      na3_ff   <= na2_ff;
      nb3_ff   <= nb2_ff;
      nc3_ff   <= nc2_ff;
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   // |c| * 2^2F / |a|, used when b is zero
   logic              d1_vld;
   logic [RNUM_W-1:0] d1_quo;
   logic [SB1_W-1:0]  d1_sb;
   logic [KIND_W-1:0] d1_kind_bits;
   kind_type          d1_kind;
   logic [DISC_W-1:0] d1_disc;
   logic [W-1:0]      d1_ma, d1_mb, d1_mc;
   logic              d1_na, d1_nb, d1_nc;

   qrs_div #(
      .NUM_W (RNUM_W),
      .DEN_W (W),
      .SB_W  (SB1_W)
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    ({mc3_ff, {(2*F){1'b0}}}),
      .in_den    (ma3_ff),
      .in_sb     ({kind3_ff, disc3_ff, ma3_ff, mb3_ff, mc3_ff, na3_ff, nb3_ff, nc3_ff}),
      .out_valid (d1_vld),
      .out_quo   (d1_quo),
      .out_rnd   (),
      .out_sb    (d1_sb)
   );

   assign {d1_kind_bits, d1_disc, d1_ma, d1_mb, d1_mc, d1_na, d1_nb, d1_nc} = d1_sb;
   assign d1_kind = kind_type'(d1_kind_bits);

   // square root of the discriminant or of the ratio
   logic [SQ_W-1:0]   sq_rad;
   logic              sq_vld;
   logic [RT_W-1:0]   sq_root;
   logic [SB2_W-1:0]  sq_sb;
   logic [KIND_W-1:0] sq_kind_bits;
   kind_type          sq_kind;
   logic [W-1:0]      sq_ma, sq_mb, sq_mc;
   logic              sq_na, sq_nb, sq_nc;
   assign sq_rad = (d1_kind == KIND_BZERO) ? SQ_W'(d1_quo) : SQ_W'(d1_disc);

   qrs_sqrt #(
      .RAD_W (SQ_W),
      .SB_W  (SB2_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_vld),
      .in_rad    (sq_rad),
      .in_sb     ({d1_kind_bits, d1_ma, d1_mb, d1_mc, d1_na, d1_nb, d1_nc}),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_sb    (sq_sb)
   );

   assign {sq_kind_bits, sq_ma, sq_mb, sq_mc, sq_na, sq_nb, sq_nc} = sq_sb;
   assign sq_kind = kind_type'(sq_kind_bits);

   // divider operands
   logic             v5_ff;
   logic [T_W-1:0]   t_sum;
   logic [QN_W-1:0]  da_num_ff, db_num_ff;
   logic [T_W-1:0]   da_den_ff;
   logic [W:0]       db_den_ff;
   logic [SBA_W-1:0] sba_ff;
   logic             neg2_5_ff;
   assign t_sum = T_W'(sq_mb) + T_W'(sq_root[W:0]);
   always_ff @(posedge clock) begin
      da_num_ff <= (sq_kind == KIND_LIN) ? QN_W'({sq_mc, {F{1'b0}}})
                                         : QN_W'({sq_mc, {(F+1){1'b0}}});
      da_den_ff <= (sq_kind == KIND_LIN) ? T_W'(sq_mb) : t_sum;
      db_num_ff <= {t_sum, {F{1'b0}}};
      db_den_ff <= {sq_ma, 1'b0};
      sba_ff    <= {sq_kind_bits, sq_root, (sq_mc != '0) && (sq_nc == sq_nb)};
      neg2_5_ff <= sq_nb == sq_na;
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= sq_vld;
      end
   end

   // c/q and q/a side by side
   logic             da_vld, da_rnd, db_vld, db_rnd, db_sb;
   logic [QN_W-1:0]  da_quo, db_quo;
   logic [SBA_W-1:0] da_sb;

   qrs_div #(
      .NUM_W (QN_W),
      .DEN_W (T_W),
      .SB_W  (SBA_W)
   ) u_div_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (da_num_ff),
      .in_den    (da_den_ff),
      .in_sb     (sba_ff),
      .out_valid (da_vld),
      .out_quo   (da_quo),
      .out_rnd   (da_rnd),
      .out_sb    (da_sb)
   );

   qrs_div #(
      .NUM_W (QN_W),
      .DEN_W (W + 1),
      .SB_W  (1)
   ) u_div_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (db_num_ff),
      .in_den    (db_den_ff),
      .in_sb     (neg2_5_ff),
      .out_valid (db_vld),
      .out_quo   (db_quo),
      .out_rnd   (db_rnd),
      .out_sb    (db_sb)
   );

   // rounding
   logic              v6_ff;
   logic [QR_W-1:0]   m1_6_ff, m2_6_ff;
   logic [KIND_W-1:0] kind6_bits;
   logic [RT_W-1:0]   s6_in;
   logic              neg1_6_in;
   kind_type          kind6_ff;
   logic [RT_W-1:0]   s6_ff;
   logic              neg1_6_ff, neg2_6_ff;
   assign {kind6_bits, s6_in, neg1_6_in} = da_sb;
   always_ff @(posedge clock) begin
      m1_6_ff   <= QR_W'(da_quo) + QR_W'(da_rnd);
      m2_6_ff   <= QR_W'(db_quo) + QR_W'(db_rnd);
      kind6_ff  <= kind_type'(kind6_bits);
      s6_ff     <= s6_in;
      neg1_6_ff <= neg1_6_in;
      neg2_6_ff <= db_sb;
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= da_vld;
      end
   end

   // clip to the word range
   logic         v7_ff;
   logic [W:0]   c1, c2;
   logic [W-1:0] r1_in, r2_in;
   logic         sat_in;
   logic [1:0]   cnt_in;
   logic [W-1:0] r1_7_ff, r2_7_ff;
   logic         sat7_ff;
   logic [1:0]   cnt7_ff;
   always_comb begin
      c1     = '0;
      c2     = '0;
      r1_in  = '0;
      r2_in  = '0;
      sat_in = 1'b0;
      cnt_in = CNT_NONE;
      unique case (kind6_ff)
         KIND_NONE: begin
            cnt_in = CNT_NONE;
         end
         KIND_LIN: begin
            c1     = clip(EM_W'(m1_6_ff), neg1_6_ff);
            r1_in  = c1[W-1:0];
            sat_in = c1[W];
            cnt_in = CNT_ONE;
         end
         KIND_BZERO: begin
            c1     = clip(EM_W'(s6_ff), 1'b1);
            c2     = clip(EM_W'(s6_ff), 1'b0);
            r1_in  = c1[W-1:0];
            r2_in  = c2[W-1:0];
            sat_in = c1[W] | c2[W];
            cnt_in = CNT_TWO;
         end
         KIND_GEN: begin
            c1     = clip(EM_W'(m1_6_ff), neg1_6_ff);
            c2     = clip(EM_W'(m2_6_ff), neg2_6_ff);
            r1_in  = c1[W-1:0];
            r2_in  = c2[W-1:0];
            sat_in = c1[W] | c2[W];
            cnt_in = CNT_TWO;
         end
         default: begin
            cnt_in = CNT_NONE;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      r1_7_ff <= r1_in;
      r2_7_ff <= r2_in;
      sat7_ff <= sat_in;
      cnt7_ff <= cnt_in;
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
   end

   // ascending order and output register
   logic         swap;
   logic         out_vld_ff;
   logic [W-1:0] first_ff, second_ff;
   logic         sat_ff;
   logic [1:0]   cnt_ff;
   assign swap = (cnt7_ff == CNT_TWO) && ($signed(r1_7_ff) > $signed(r2_7_ff));
   always_ff @(posedge clock) begin
      first_ff  <= swap ? r2_7_ff : r1_7_ff;
      second_ff <= swap ? r1_7_ff : r2_7_ff;
      sat_ff    <= sat7_ff;
      cnt_ff    <= cnt7_ff;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= v7_ff;
      end
   end

   assign rsp_strobe      = out_vld_ff;
   assign rsp_root_count  = cnt_ff;
   assign rsp_first_root  = first_ff;
   assign rsp_second_root = second_ff;
   assign rsp_saturated   = sat_ff;

`ifndef SYNTH
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      da_vld == db_vld)
      else $error("root dividers out of step");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_root_count <= CNT_TWO)
      else $error("root count out of range");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_root_count == CNT_TWO |-> rsp_first_root <= rsp_second_root)
      else $error("roots not ascending");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_root_count == CNT_NONE
      |-> rsp_first_root == '0 && rsp_second_root == '0 && !rsp_saturated)
      else $error("absent roots not cleared");
`endif

endmodule

`default_nettype wire
